// File: design/calendar_date_advance_unit_assert.svh
// ----------------------------------------------------------------------------
// Calendar date advance unit - assertion macros
// Shared property macros clocked on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADVANCE_UNIT_ASSERT_SVH
`define CALENDAR_DATE_ADVANCE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cda_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date advance package
// Widths, codes, state type and Gregorian calendar helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int DAYS_IN_W = 16;
    localparam int LEN_W     = 9;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam int BASE_YEAR    = 1900;
    localparam int DEFAULT_YEAR = 2000;
    localparam int MONTHS       = 12;
    localparam int FEB_DAYS     = 28;
    localparam int YEAR_DAYS    = 365;

    // Divisibility by 100 is found from y * ceil(2^19 / 100): exact multiples leave a
    // fraction below 2^11, all other years leave at least 0.01 * 2^19.
    localparam int LEAP_MUL    = 5243;
    localparam int LEAP_MUL_W  = 13;
    localparam int LEAP_FRAC_W = 19;
    localparam int LEAP_TOL_W  = 11;
    localparam int LEAP_PROD_W = YEAR_W + 1 + LEAP_MUL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [1:0] {
        REG_START_DAY   = 2'd0,
        REG_START_MONTH = 2'd1,
        REG_START_YEAR  = 2'd2
    } t_reg_idx;

    function automatic logic is_leap(input logic [YEAR_W:0] y);
        logic [LEAP_PROD_W-1:0] prod;
        logic                   div100;
        logic [1:0]             q_lo;
        prod   = LEAP_PROD_W'(y) * LEAP_PROD_W'(LEAP_MUL);
        div100 = (prod[LEAP_FRAC_W-1:LEAP_TOL_W] == '0);
        q_lo   = prod[LEAP_FRAC_W+1:LEAP_FRAC_W];
        return ((y[1:0] == 2'b00) && !div100) || (div100 && (q_lo == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_W'(2)) begin
            len = DAY_W'(FEB_DAYS) + DAY_W'(leap);
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = DAY_W'(30);
        end else begin
            len = DAY_W'(31);
        end
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] year_len(input logic leap);
        return LEN_W'(YEAR_DAYS) + LEN_W'(leap);
    endfunction

endpackage

`default_nettype wire

// File: design/cda_step_unit.sv
// ----------------------------------------------------------------------------
// Calendar date advance - shared step unit
// One adder/subtractor with a compare, reused for every month and year step.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_step_unit #(
    parameter int TOT_W = 17
) (
    input  var cda_pkg::t_alu_op           i_op,
    input  var logic [TOT_W-1:0]           i_a,
    input  var logic [cda_pkg::LEN_W-1:0]  i_b,
    output var logic [TOT_W-1:0]           o_res,
    output var logic                       o_ge
);
    import cda_pkg::*;

    logic [TOT_W-1:0] b_ext;

    assign b_ext = TOT_W'(i_b);
    assign o_ge  = (i_a >= b_ext);

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = i_a + b_ext;
            ALU_SUB: o_res = i_a - b_ext;
            default: o_res = i_a;
        endcase
    end

endmodule

`default_nettype wire

// File: design/calendar_date_advance_unit.sv
// ----------------------------------------------------------------------------
// Calendar date advance unit
// Holds a Gregorian date and moves it forward by a day count per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  request   in         i_valid / o_stall    i_days_to_add
//  result    out        o_valid / i_stall    o_day, o_month, o_year, o_overflow
//  config    in         APB psel / penable   paddr, pwdata, prdata
//
// A request first adds the months before the start month, then strips whole years
// and then whole months; the single shared adder in cda_step_unit does
// one month or one year per cycle. o_stall is high from acceptance until the
// result moves into the output register. Synchronous reset restores 1.1.2000.
// A stalled result holds while the next request is already being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_advance_unit #(
    parameter int MAX_YEAR       = 9999,
    parameter int DAY_COUNT_BITS = 16
) (
    input  var logic                            i_clk,
    input  var logic                            i_rst_n,
    input  var logic                            i_valid,
    output var logic                            o_stall,
    input  var logic [cda_pkg::DAYS_IN_W-1:0]   i_days_to_add,
    output var logic                            o_valid,
    input  var logic                            i_stall,
    output var logic [cda_pkg::DAY_W-1:0]       o_day,
    output var logic [cda_pkg::MONTH_W-1:0]     o_month,
    output var logic [cda_pkg::YEAR_W-1:0]      o_year,
    output var logic                            o_overflow,
    input  var logic                            psel,
    input  var logic                            penable,
    input  var logic                            pwrite,
    input  var logic [cda_pkg::ADDR_W-1:0]      paddr,
    input  var logic [cda_pkg::DATA_W-1:0]      pwdata,
    output var logic [cda_pkg::DATA_W-1:0]      prdata,
    output var logic                            pready
);
    import cda_pkg::*;

    localparam int USE_BITS = (DAY_COUNT_BITS < DAYS_IN_W) ? DAY_COUNT_BITS : DAYS_IN_W;
    localparam int TOT_W    = ((USE_BITS > LEN_W) ? USE_BITS : LEN_W) + 1;

    t_state               r_state, n_state;
    logic [DAY_W-1:0]     r_start_day, n_start_day;
    logic [MONTH_W-1:0]   r_start_month, n_start_month;
    logic [YEAR_W-1:0]    r_start_year, n_start_year;
    logic [DAY_W-1:0]     r_cur_day, n_cur_day;
    logic [MONTH_W-1:0]   r_cur_month, n_cur_month;
    logic [YEAR_W-1:0]    r_cur_year, n_cur_year;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [MONTH_W-1:0]   r_m, n_m;
    logic [YEAR_W:0]      r_y, n_y;
    logic [YEAR_W:0]      r_yn, n_yn;
    logic                 r_leap, n_leap;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [DAY_W-1:0]     r_out_day, n_out_day;
    logic [MONTH_W-1:0]   r_out_month, n_out_month;
    logic [YEAR_W-1:0]    r_out_year, n_out_year;
    logic                 r_out_ovf, n_out_ovf;

    logic                 in_acc;
    logic                 out_free;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;
    logic                 start_ok;
    t_alu_op              alu_op;
    logic [LEN_W-1:0]     alu_b;
    logic [TOT_W-1:0]     alu_res;
    logic                 alu_ge;
    logic                 more_months;
    logic                 year_over;

    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign more_months = (r_m < MONTH_W'(MONTHS)) && alu_ge;
    assign year_over   = (r_yn > (YEAR_W+1)'(MAX_YEAR));

    cda_step_unit #(
        .TOT_W (TOT_W)
    ) u_step (
        .i_op  (alu_op),
        .i_a   (r_total),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_ge  (alu_ge)
    );

    always_comb begin
        alu_op = (r_state == ST_PREP) ? ALU_ADD : ALU_SUB;
        alu_b  = (r_state == ST_YEARS) ? year_len(r_leap) : LEN_W'(month_len(r_m, r_leap));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_m >= r_cur_month) begin
                    n_state = ST_YEARS;
                end
            end
            ST_YEARS: begin
                if (!alu_ge) begin
                    n_state = ST_MONTHS;
                end else if (year_over) begin
                    n_state = ST_FINISH;
                end
            end
            ST_MONTHS: begin
                if (!more_months) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_total       = r_total;
        n_m           = r_m;
        n_y           = r_y;
        n_yn          = r_yn;
        n_leap        = r_leap;
        n_ovf         = r_ovf;
        n_cur_day     = r_cur_day;
        n_cur_month   = r_cur_month;
        n_cur_year    = r_cur_year;
        n_out_valid   = r_out_valid && i_stall;
        n_out_day     = r_out_day;
        n_out_month   = r_out_month;
        n_out_year    = r_out_year;
        n_out_ovf     = r_out_ovf;
        n_start_day   = r_start_day;
        n_start_month = r_start_month;
        n_start_year  = r_start_year;
        start_ok      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // Day offset within the current year starts from the day of month.
                    n_total = TOT_W'(r_cur_day) - TOT_W'(1)
                            + TOT_W'(i_days_to_add[USE_BITS-1:0]);
                    n_m     = MONTH_W'(1);
                    n_y     = (YEAR_W+1)'(r_cur_year);
                    n_yn    = (YEAR_W+1)'(r_cur_year) + (YEAR_W+1)'(1);
                    n_leap  = is_leap((YEAR_W+1)'(r_cur_year));
                    n_ovf   = 1'b0;
                end
            end
            ST_PREP: begin
                if (r_m < r_cur_month) begin
                    n_total = alu_res;
                    n_m     = r_m + MONTH_W'(1);
                end
            end
            ST_YEARS: begin
                if (alu_ge) begin
                    n_total = alu_res;
                    n_y     = r_yn;
                    n_yn    = r_yn + (YEAR_W+1)'(1);
                    n_leap  = is_leap(r_yn);
                    n_ovf   = year_over;
                end else begin
                    n_m = MONTH_W'(1);
                end
            end
            ST_MONTHS: begin
                if (more_months) begin
                    n_total = alu_res;
                    n_m     = r_m + MONTH_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (r_ovf) begin
                        n_cur_day   = DAY_W'(31);
                        n_cur_month = MONTH_W'(MONTHS);
                        n_cur_year  = YEAR_W'(MAX_YEAR);
                    end else begin
                        n_cur_day   = r_total[DAY_W-1:0] + DAY_W'(1);
                        n_cur_month = r_m;
                        n_cur_year  = r_y[YEAR_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_out_day   = n_cur_day;
                    n_out_month = n_cur_month;
                    n_out_year  = n_cur_year;
                    n_out_ovf   = r_ovf;
                end
            end
            default: ;
        endcase

        // Any start register write reloads the stored date from all three, or 1.1.2000 if they form no valid date.
        if (cfg_wr) begin
            case (cfg_idx)
                REG_START_DAY:   n_start_day   = pwdata[DAY_W-1:0];
                REG_START_MONTH: n_start_month = pwdata[MONTH_W-1:0];
                REG_START_YEAR:  n_start_year  = pwdata[YEAR_W-1:0];
                default: ;
            endcase
            start_ok = (n_start_month >= MONTH_W'(1)) && (n_start_month <= MONTH_W'(MONTHS))
                    && (n_start_year >= YEAR_W'(BASE_YEAR))
                    && (n_start_year <= YEAR_W'(MAX_YEAR))
                    && (n_start_day >= DAY_W'(1))
                    && (n_start_day <= month_len(n_start_month,
                                                 is_leap((YEAR_W+1)'(n_start_year))));
            case (cfg_idx)
                REG_START_DAY, REG_START_MONTH, REG_START_YEAR: begin
                    n_cur_day   = start_ok ? n_start_day   : DAY_W'(1);
                    n_cur_month = start_ok ? n_start_month : MONTH_W'(1);
                    n_cur_year  = start_ok ? n_start_year  : YEAR_W'(DEFAULT_YEAR);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_START_DAY:   prdata = DATA_W'(r_start_day);
            REG_START_MONTH: prdata = DATA_W'(r_start_month);
            REG_START_YEAR:  prdata = DATA_W'(r_start_year);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_start_day   <= DAY_W'(1);
            r_start_month <= MONTH_W'(1);
            r_start_year  <= YEAR_W'(DEFAULT_YEAR);
            r_cur_day     <= DAY_W'(1);
            r_cur_month   <= MONTH_W'(1);
            r_cur_year    <= YEAR_W'(DEFAULT_YEAR);
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_start_day   <= n_start_day;
            r_start_month <= n_start_month;
            r_start_year  <= n_start_year;
            r_cur_day     <= n_cur_day;
            r_cur_month   <= n_cur_month;
            r_cur_year    <= n_cur_year;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total     <= n_total;
        r_m         <= n_m;
        r_y         <= n_y;
        r_yn        <= n_yn;
        r_leap      <= n_leap;
        r_ovf       <= n_ovf;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_day      = r_out_day;
    assign o_month    = r_out_month;
    assign o_year     = r_out_year;
    assign o_overflow = r_out_ovf;
    assign pready     = 1'b1;

endmodule

`default_nettype wire

// File: design/cda_checker.sv
// ----------------------------------------------------------------------------
// Calendar date advance - port checker
// Watches the top level's ports and is attached to it with a bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_advance_unit_assert.svh"

module cda_checker #(
    parameter int MAX_YEAR = 9999
) (
    input var logic                            i_clk,
    input var logic                            i_rst_n,
    input var logic                            i_valid,
    input var logic                            o_stall,
    input var logic                            o_valid,
    input var logic                            i_stall,
    input var logic [cda_pkg::DAY_W-1:0]       o_day,
    input var logic [cda_pkg::MONTH_W-1:0]     o_month,
    input var logic [cda_pkg::YEAR_W-1:0]      o_year,
    input var logic                            o_overflow
);
    import cda_pkg::*;

    // A result that is not taken stays offered.
    `CDA_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped while stalled")

    // An accepted request keeps the block busy in the next cycle.
    `CDA_ASSERT_NEXT(a_busy_after_req, i_valid && !o_stall, o_stall, "not busy after request")

    // Every offered date has its month, its day's lower bound and its year within range.
    `CDA_ASSERT_SAME(a_date_range, o_valid,
        (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day >= 5'd1)
        && (o_year >= YEAR_W'(BASE_YEAR)) && (o_year <= YEAR_W'(MAX_YEAR)),
        "result date out of range")

    // Saturation always lands on the last day of the last year.
    `CDA_ASSERT_SAME(a_ovf_date, o_valid && o_overflow,
        (o_day == 5'd31) && (o_month == 4'd12) && (o_year == YEAR_W'(MAX_YEAR)),
        "overflow result is not the last date")

endmodule

bind calendar_date_advance_unit cda_checker #(
    .MAX_YEAR (MAX_YEAR)
) u_cda_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_day      (o_day),
    .o_month    (o_month),
    .o_year     (o_year),
    .o_overflow (o_overflow)
);

`default_nettype wire

// File: test/calendar_date_advance_unit_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date advance unit - result checker
// Watches the request, result and register channels, keeps its own copy of the
// stored date, predicts each advanced date and compares it with the result.
// ----------------------------------------------------------------------------

module calendar_date_advance_unit_check #(
    parameter int MAX_YEAR       = 9999,
    parameter int DAY_COUNT_BITS = 16
) (
    input  var logic                            i_clk,
    input  var logic                            i_rst_n,
    input  var logic                            i_valid,
    input  var logic                            o_stall,
    input  var logic [cda_pkg::DAYS_IN_W-1:0]   i_days_to_add,
    input  var logic                            o_valid,
    input  var logic                            i_stall,
    input  var logic [cda_pkg::DAY_W-1:0]       o_day,
    input  var logic [cda_pkg::MONTH_W-1:0]     o_month,
    input  var logic [cda_pkg::YEAR_W-1:0]      o_year,
    input  var logic                            o_overflow,
    input  var logic                            psel,
    input  var logic                            penable,
    input  var logic                            pwrite,
    input  var logic [cda_pkg::ADDR_W-1:0]      paddr,
    input  var logic [cda_pkg::DATA_W-1:0]      pwdata,
    input  var logic                            pready,
    output var int                              fail_count,
    output var int                              pending
);

    typedef struct packed {
        logic [cda_pkg::DAY_W-1:0]   day;
        logic [cda_pkg::MONTH_W-1:0] month;
        logic [cda_pkg::YEAR_W-1:0]  year;
        logic                        overflow;
    } cal_date_t;

    logic [cda_pkg::DAY_W-1:0]   start_day;
    logic [cda_pkg::MONTH_W-1:0] start_month;
    logic [cda_pkg::YEAR_W-1:0]  start_year;
    cal_date_t                   calendar;
    cal_date_t                   dates_due[$];

    initial fail_count = 0;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m == 2) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    // A bad start date falls back to the first day of the default year.
    function automatic void reload_start();
        if (start_month >= 1 && start_month <= 12 && start_year >= cda_pkg::BASE_YEAR &&
                start_year <= MAX_YEAR && start_day >= 1 &&
                start_day <= month_days(start_month, start_year)) begin
            calendar.day   = start_day;
            calendar.month = start_month;
            calendar.year  = start_year;
        end else begin
            calendar.day   = cda_pkg::DAY_W'(1);
            calendar.month = cda_pkg::MONTH_W'(1);
            calendar.year  = cda_pkg::YEAR_W'(cda_pkg::DEFAULT_YEAR);
        end
        calendar.overflow = 1'b0;
    endfunction

    // Turns the date into a day offset within its year, adds the count, then
    // strips whole years by their own length before locating month and day.
    function automatic cal_date_t advance_calendar(input cal_date_t from,
                                                   input logic [cda_pkg::DAYS_IN_W-1:0] n);
        longint unsigned offset;
        int unsigned     y;
        int unsigned     m;
        cal_date_t       to;
        offset = longint'(from.day) - 1;
        y      = from.year;
        for (m = 1; m < from.month && m <= 12; m++) begin
            offset += month_days(m, y);
        end
        offset += longint'(n) & ((longint'(1) << DAY_COUNT_BITS) - 1);
        to.overflow = 1'b0;
        while (offset >= year_days(y)) begin
            offset -= year_days(y);
            y++;
            if (y > MAX_YEAR) begin
                to.overflow = 1'b1;
                break;
            end
        end
        if (to.overflow) begin
            to.day   = cda_pkg::DAY_W'(31);
            to.month = cda_pkg::MONTH_W'(12);
            to.year  = cda_pkg::YEAR_W'(MAX_YEAR);
        end else begin
            m = 1;
            while (m < 12 && offset >= month_days(m, y)) begin
                offset -= month_days(m, y);
                m++;
            end
            to.day   = cda_pkg::DAY_W'(offset + 1);
            to.month = cda_pkg::MONTH_W'(m);
            to.year  = cda_pkg::YEAR_W'(y);
        end
        return to;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        cal_date_t want;
        if (!i_rst_n) begin
            start_day   = cda_pkg::DAY_W'(1);
            start_month = cda_pkg::MONTH_W'(1);
            start_year  = cda_pkg::YEAR_W'(cda_pkg::DEFAULT_YEAR);
            reload_start();
            dates_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cda_pkg::t_reg_idx'(paddr[cda_pkg::ADDR_W-1:2]))
                    cda_pkg::REG_START_DAY: begin
                        start_day = pwdata[cda_pkg::DAY_W-1:0];
                        reload_start();
                    end
                    cda_pkg::REG_START_MONTH: begin
                        start_month = pwdata[cda_pkg::MONTH_W-1:0];
                        reload_start();
                    end
                    cda_pkg::REG_START_YEAR: begin
                        start_year = pwdata[cda_pkg::YEAR_W-1:0];
                        reload_start();
                    end
                    default: begin
                    end
                endcase
            end
            // Results leave before this edge's request joins the queue.
            if (o_valid && !i_stall) begin
                if (dates_due.size() == 0) begin
                    $error("result %0d.%0d.%0d with no request outstanding",
                           o_day, o_month, o_year);
                    fail_count++;
                end else begin
                    want = dates_due.pop_front();
                    check_field("day", want.day, o_day);
                    check_field("month", want.month, o_month);
                    check_field("year", want.year, o_year);
                    check_field("overflow", want.overflow, o_overflow);
                end
            end
            if (i_valid && !o_stall) begin
                calendar = advance_calendar(calendar, i_days_to_add);
                dates_due.push_back(calendar);
            end
        end
        pending <= dates_due.size();
    end

endmodule

// File: test/calendar_date_advance_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date advance unit - testbench
// Drives day counts and start-date register writes into the unit, first a
// directed set around month, leap year and year-limit boundaries, then random
// counts under varying start dates, with random gaps and result back-pressure.
// ----------------------------------------------------------------------------

module calendar_date_advance_unit_test;

    localparam int         MAX_YEAR       = 9999;
    localparam int         DAY_COUNT_BITS = 16;
    localparam int         CHUNKS         = 40;
    localparam int         CHUNK_REQUESTS = 50;
    localparam int         DRAIN_CYCLES   = 250;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            i_valid       = 1'b0;
    logic [cda_pkg::DAYS_IN_W-1:0]   i_days_to_add = '0;
    logic                            i_stall       = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [cda_pkg::ADDR_W-1:0]      paddr         = '0;
    logic [cda_pkg::DATA_W-1:0]      pwdata        = '0;
    logic                            o_stall;
    logic                            o_valid;
    logic [cda_pkg::DAY_W-1:0]       o_day;
    logic [cda_pkg::MONTH_W-1:0]     o_month;
    logic [cda_pkg::YEAR_W-1:0]      o_year;
    logic                            o_overflow;
    logic [cda_pkg::DATA_W-1:0]      prdata;
    logic                            pready;
    int                              fail_count;
    int                              pending;
    int                              send_idle_pct = 0;
    int                              stall_pct     = 0;

    calendar_date_advance_unit #(
        .MAX_YEAR       (MAX_YEAR),
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_days_to_add (i_days_to_add),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_day         (o_day),
        .o_month       (o_month),
        .o_year        (o_year),
        .o_overflow    (o_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    calendar_date_advance_unit_check #(
        .MAX_YEAR       (MAX_YEAR),
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_days_to_add (i_days_to_add),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_day         (o_day),
        .o_month       (o_month),
        .o_year        (o_year),
        .o_overflow    (o_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every task below starts and ends right after a rising edge.
    task automatic push_days(input logic [cda_pkg::DAYS_IN_W-1:0] n);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_days_to_add <= n;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_requests();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // With noisy set, the bits above the register's field carry random junk.
    task automatic reg_write(input logic [1:0] idx, input int value, input bit noisy);
        logic [cda_pkg::DATA_W-1:0] keep;
        case (idx)
            cda_pkg::REG_START_DAY:   keep = cda_pkg::DATA_W'((1 << cda_pkg::DAY_W) - 1);
            cda_pkg::REG_START_MONTH: keep = cda_pkg::DATA_W'((1 << cda_pkg::MONTH_W) - 1);
            cda_pkg::REG_START_YEAR:  keep = cda_pkg::DATA_W'((1 << cda_pkg::YEAR_W) - 1);
            default:                  keep = '1;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cda_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= noisy ? ((cda_pkg::DATA_W'($urandom()) & ~keep) | (value & keep))
                         : cda_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_date(input int d, input int m, input int y, input bit noisy);
        reg_write(cda_pkg::REG_START_DAY, d, noisy);
        reg_write(cda_pkg::REG_START_MONTH, m, noisy);
        reg_write(cda_pkg::REG_START_YEAR, y, noisy);
    endtask

    initial begin
        int                            d;
        int                            m;
        int                            y;
        int                            pick;
        logic [1:0]                    idx;
        logic [cda_pkg::DAYS_IN_W-1:0] n;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // From the reset date: zero days, month ends, leap February, largest count.
        push_days(0);
        push_days(30);
        push_days(29);
        push_days(1);
        push_days(306);
        push_days('1);
        drain_requests();

        // Last representable day, then one step past it, then zero after saturation.
        write_date(31, 12, MAX_YEAR, 1'b0);
        push_days(0);
        push_days(1);
        push_days(0);
        drain_requests();

        // The base year is a century year and therefore not leap.
        write_date(1, 1, cda_pkg::BASE_YEAR, 1'b0);
        push_days(58);
        push_days(1);
        drain_requests();

        write_date(29, 2, cda_pkg::BASE_YEAR, 1'b0);
        push_days(0);
        drain_requests();

        // A year divisible by 400 is leap again.
        write_date(29, 2, 2400, 1'b0);
        push_days(0);
        push_days(365);
        drain_requests();

        // Field extremes that form no valid date.
        write_date(0, 15, (1 << cda_pkg::YEAR_W) - 1, 1'b0);
        push_days(0);
        drain_requests();
        write_date(31, 0, 0, 1'b0);
        push_days(0);
        drain_requests();
        write_date(31, 4, 2020, 1'b0);
        push_days(0);
        drain_requests();
        write_date(1, 1, cda_pkg::BASE_YEAR - 1, 1'b0);
        push_days(0);
        drain_requests();

        // The largest count runs past the year limit from late in the range.
        write_date(1, 1, 9900, 1'b0);
        push_days('1);
        drain_requests();

        // A write to an unmapped register must leave the advanced date alone.
        write_date(15, 6, 2010, 1'b0);
        push_days(10);
        drain_requests();
        reg_write(REG_UNUSED, 31, 1'b0);
        push_days(0);
        drain_requests();

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default: begin
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
            endcase

            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                y = $urandom_range(cda_pkg::BASE_YEAR, MAX_YEAR);
                m = $urandom_range(1, 12);
                d = ($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
                write_date(d, m, y, 1'b1);
            end else if (pick < 85) begin
                idx = $urandom_range(0, 2);
                case (idx)
                    cda_pkg::REG_START_DAY:   reg_write(idx, $urandom_range(1, 31), 1'b1);
                    cda_pkg::REG_START_MONTH: reg_write(idx, $urandom_range(1, 12), 1'b1);
                    default: reg_write(idx, $urandom_range(cda_pkg::BASE_YEAR, MAX_YEAR), 1'b1);
                endcase
            end else if (pick < 95) begin
                write_date($urandom_range(0, 31), $urandom_range(0, 15),
                           $urandom_range(0, (1 << cda_pkg::YEAR_W) - 1), 1'b1);
            end else begin
                reg_write(REG_UNUSED, $urandom(), 1'b0);
            end

            // Mostly short hops so the date wanders instead of saturating at once.
            for (int k = 0; k < CHUNK_REQUESTS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    n = $urandom_range(0, 60);
                end else if (pick < 80) begin
                    n = $urandom_range(0, 800);
                end else if (pick < 92) begin
                    n = $urandom_range(0, 10000);
                end else begin
                    n = $urandom_range(0, (1 << cda_pkg::DAYS_IN_W) - 1);
                end
                push_days(n);
            end
            drain_requests();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/cda_pkg.sv
design/cda_step_unit.sv
design/calendar_date_advance_unit.sv
design/cda_checker.sv
test/calendar_date_advance_unit_check.sv
test/calendar_date_advance_unit_test.sv
